### hw/rtl/gfa_pkg.sv
// gravity field accumulator package: constants, payload types, controller types
// no dependencies; imported by every module of the block
package gfa_pkg;

    localparam int DATA_W        = 32;
    localparam int SOFT_W        = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_WIDTH_DEF = 48;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOFTENING_SQ = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] GRAV_CONST_RST = 32'h0001_0000;
    localparam logic [SOFT_W-1:0] SOFT_SQ_RST    = 16'd7;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;
    localparam int AXIS_W     = 2;
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
        logic signed [DATA_W-1:0] body_x;
        logic signed [DATA_W-1:0] body_y;
        logic signed [DATA_W-1:0] body_z;
        logic        [DATA_W-1:0] body_mass;
        logic                     last_body;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] field_x;
        logic signed [DATA_W-1:0] field_y;
        logic signed [DATA_W-1:0] field_z;
        logic                     saturated;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    value;
    } t_cfg;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_GM,
        MUL_MAG_LO,
        MUL_MAG_HI
    } t_mul_sel;

    typedef enum logic {
        DIV_MAG,
        DIV_CMP
    } t_div_src;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_INIT,
        S_SQRT,
        S_GM_MUL,
        S_GM_ACC,
        S_MAG_INIT,
        S_MAG_DIV,
        S_MAG_LD,
        S_LO_MUL,
        S_LO_ACC,
        S_HI_MUL,
        S_HI_ACC,
        S_C_INIT,
        S_C_DIV,
        S_C_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic [AXIS_W-1:0] axis;
        logic              s_clr;
        logic              s_add;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              gm_ld;
        logic              div_init;
        t_div_src          div_src;
        logic              div_step;
        logic              mag_ld;
        logic              p_lo;
        logic              p_hi;
        logic              sum_acc;
        logic              sum_clr;
        logic              out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic l_zero;
        logic last;
    } t_dp_stat;

endpackage

### hw/rtl/gfa_stream_if.sv
// valid/ready channel carrying one payload beat of type T
// depends on nothing; payload types come from gfa_pkg at the point of use
interface gfa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gravity_field_accumulator.sv
// Softened gravity field accumulator. Each input beat pairs a sample point with one body;
// the block adds G*m/(|r|^2 + s^2) along r = body - point to a three-axis running sum and,
// on a beat with last_body set, returns the sum clipped to signed Q16.16 with a saturated
// flag, then clears it. A body sitting exactly on the point adds nothing. Items are handled
// one at a time: the next item is taken only once the current one is finished, which
// for an item marked last includes any wait for the previous result beat to be taken.
// Run time is set by the single bit-serial divider, which runs four 64-step divisions
// per item (the magnitude, then one per axis; none when body and point coincide), and
// by the 32-step bit-serial square root; one shared 32x32 multiplier forms the squares,
// G*m and the two halves of magnitude times distance. A finished result waits in its own
// output register, so the next item is accepted while that beat is still pending.
// Configuration beats (index 0: grav_const, index 1: softening_sq; other indexes ignored)
// are always taken and must only be sent while the block is idle.
// depends on gfa_pkg, gfa_stream_if, gfa_ctrl, gfa_datapath
module gravity_field_accumulator import gfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gfa_stream_if.sink   i_item,
    gfa_stream_if.source o_result,
    gfa_stream_if.sink   i_cfg
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_item    w_item;
    t_cfg     w_cfg;
    t_result  w_result;
    logic     w_cfg_we;

    // payload views of the channels
    assign w_item = i_item.data;
    assign w_cfg  = i_cfg.data;

    // config beats are taken at once; registers live in the datapath
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    gfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .o_out_valid(o_result.valid),
        .i_out_ready(o_result.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gfa_datapath #(
        .FRAC_BITS(FRAC_BITS),
        .SUM_WIDTH(SUM_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (w_cfg_we),
        .i_cfg    (w_cfg),
        .i_item   (w_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    // result beat payload comes straight from the datapath output register
    assign o_result.data = w_result;

endmodule

### hw/rtl/gfa_datapath.sv
// datapath: config registers, shared 32x32 multiplier, bit-serial sqrt and divider, sums
// depends on gfa_pkg; driven by gfa_ctrl through t_dp_cmd
module gfa_datapath import gfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg     i_cfg,
    input  t_item    i_item,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_result  o_result
);
    localparam logic [63:0] SUM_MAX64 = 64'((65'd1 << (SUM_WIDTH - 1)) - 65'd1);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = SUM_WIDTH'(SUM_MAX64);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = ~SUM_MAX;

    logic [DATA_W-1:0] r_grav;
    logic [SOFT_W-1:0] r_soft;

    logic [DATA_W-1:0] r_a [3];
    logic [2:0]        r_neg;
    logic              r_e;
    logic [DATA_W-1:0] r_m;
    logic              r_last;

    logic [63:0]  r_prod;
    logic [63:0]  r_s;
    logic [63:0]  r_gm;
    logic [63:0]  r_mag;
    logic [95:0]  r_p;

    logic [63:0]  r_sx;
    logic [33:0]  r_srem;
    logic [31:0]  r_root;

    logic [63:0]  r_rem;
    logic [63:0]  r_dlo;
    logic [63:0]  r_dvs;
    logic [63:0]  r_quo;
    logic         r_dsat;

    logic signed [SUM_WIDTH-1:0] r_sum [3];
    t_result      r_out;

    // item capture: |body - point| per axis, halved on all axes if any reaches 2^31
    logic signed [32:0] w_r [3];
    logic [32:0]        w_abs [3];
    logic               w_e;

    always_comb begin
        w_r[0] = {i_item.body_x[31], i_item.body_x} - {i_item.point_x[31], i_item.point_x};
        w_r[1] = {i_item.body_y[31], i_item.body_y} - {i_item.point_y[31], i_item.point_y};
        w_r[2] = {i_item.body_z[31], i_item.body_z} - {i_item.point_z[31], i_item.point_z};
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = w_r[i][32] ? 33'(-w_r[i]) : 33'(w_r[i]);
        end
        w_e = (w_abs[0][32:31] != 2'b00) || (w_abs[1][32:31] != 2'b00)
           || (w_abs[2][32:31] != 2'b00);
    end

    // shared multiplier operands
    logic [DATA_W-1:0] w_a_ax;
    logic [DATA_W-1:0] w_opa;
    logic [DATA_W-1:0] w_opb;
    logic              w_neg_ax;

    always_comb begin
        case (i_cmd.axis)
            2'd0:    begin w_a_ax = r_a[0]; w_neg_ax = r_neg[0]; end
            2'd1:    begin w_a_ax = r_a[1]; w_neg_ax = r_neg[1]; end
            2'd2:    begin w_a_ax = r_a[2]; w_neg_ax = r_neg[2]; end
            default: begin w_a_ax = '0;     w_neg_ax = 1'b0;     end
        endcase
        case (i_cmd.mul_sel)
            MUL_SQ:     begin w_opa = w_a_ax;        w_opb = w_a_ax; end
            MUL_GM:     begin w_opa = r_grav;        w_opb = r_m;    end
            MUL_MAG_LO: begin w_opa = r_mag[31:0];   w_opb = w_a_ax; end
            MUL_MAG_HI: begin w_opa = r_mag[63:32];  w_opb = w_a_ax; end
            default:    begin w_opa = '0;            w_opb = '0;     end
        endcase
    end

    // sqrt step: one result bit per cycle
    logic [35:0] w_sq_sh;
    logic [35:0] w_sq_diff;
    logic        w_sq_bit;

    always_comb begin
        w_sq_sh   = {r_srem, r_sx[63:62]};
        w_sq_diff = w_sq_sh - {2'b00, r_root, 2'b01};
        w_sq_bit  = !w_sq_diff[35];
    end

    // divider setup and step
    logic [127:0] w_gm_sh;
    logic [63:0]  w_soft_sh;
    logic [63:0]  w_d_hi;
    logic [63:0]  w_d_lo;
    logic [63:0]  w_d_dvs;
    logic [64:0]  w_rem_sh;
    logic         w_q_bit;
    logic [63:0]  w_div_res;

    always_comb begin
        if (r_e) begin
            w_gm_sh   = {64'b0, r_gm} << (FRAC_BITS - 2);
            w_soft_sh = {48'b0, r_soft} << (FRAC_BITS - 2);
        end else begin
            w_gm_sh   = {64'b0, r_gm} << FRAC_BITS;
            w_soft_sh = {48'b0, r_soft} << FRAC_BITS;
        end
        case (i_cmd.div_src)
            DIV_MAG: begin
                w_d_hi  = w_gm_sh[127:64];
                w_d_lo  = w_gm_sh[63:0];
                w_d_dvs = r_s + w_soft_sh;
            end
            DIV_CMP: begin
                w_d_hi  = {32'b0, r_p[95:64]};
                w_d_lo  = r_p[63:0];
                w_d_dvs = {32'b0, r_root};
            end
            default: begin
                w_d_hi  = '0;
                w_d_lo  = '0;
                w_d_dvs = '0;
            end
        endcase
        w_rem_sh  = {r_rem, r_dlo[63]};
        w_q_bit   = w_rem_sh >= {1'b0, r_dvs};
        w_div_res = r_dsat ? '1 : r_quo;
    end

    // saturating accumulate of one component
    logic [SUM_WIDTH-1:0]        w_c;
    logic signed [SUM_WIDTH-1:0] w_sum_ax;
    logic signed [SUM_WIDTH:0]   w_acc;
    logic signed [SUM_WIDTH-1:0] w_sum_new;

    always_comb begin
        w_c = (w_div_res > SUM_MAX64) ? SUM_WIDTH'(SUM_MAX64) : w_div_res[SUM_WIDTH-1:0];
        case (i_cmd.axis)
            2'd0:    w_sum_ax = r_sum[0];
            2'd1:    w_sum_ax = r_sum[1];
            2'd2:    w_sum_ax = r_sum[2];
            default: w_sum_ax = '0;
        endcase
        if (w_neg_ax) begin
            w_acc = {w_sum_ax[SUM_WIDTH-1], w_sum_ax} - {1'b0, w_c};
        end else begin
            w_acc = {w_sum_ax[SUM_WIDTH-1], w_sum_ax} + {1'b0, w_c};
        end
        if (w_acc[SUM_WIDTH] != w_acc[SUM_WIDTH-1]) begin
            w_sum_new = w_neg_ax ? SUM_MIN : SUM_MAX;
        end else begin
            w_sum_new = w_acc[SUM_WIDTH-1:0];
        end
    end

    // clip a sum to 32-bit signed range
    function automatic logic [DATA_W:0] clip32(input logic signed [SUM_WIDTH-1:0] v);
        logic sgn;
        logic uni;
        sgn = v[SUM_WIDTH-1];
        uni = (v[SUM_WIDTH-1:DATA_W-1] == '0) || (v[SUM_WIDTH-1:DATA_W-1] == '1);
        if (uni) begin
            clip32 = {1'b0, v[DATA_W-1:0]};
        end else begin
            clip32 = {1'b1, sgn, {(DATA_W-1){!sgn}}};
        end
    endfunction

    logic [DATA_W:0] w_cx;
    logic [DATA_W:0] w_cy;
    logic [DATA_W:0] w_cz;

    always_comb begin
        w_cx = clip32(r_sum[0]);
        w_cy = clip32(r_sum[1]);
        w_cz = clip32(r_sum[2]);
    end

    // config registers and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_CONST_RST;
            r_soft <= SOFT_SQ_RST;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg.index == REG_GRAV_CONST) begin
                r_grav <= i_cfg.value;
            end
            if (i_cfg_we && i_cfg.index == REG_SOFTENING_SQ) begin
                r_soft <= i_cfg.value[SOFT_W-1:0];
            end
            if (i_cmd.sum_clr) begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= '0;
                end
            end else if (i_cmd.sum_acc) begin
                case (i_cmd.axis)
                    2'd0:    r_sum[0] <= w_sum_new;
                    2'd1:    r_sum[1] <= w_sum_new;
                    2'd2:    r_sum[2] <= w_sum_new;
                    default: r_sum[0] <= r_sum[0];
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i]   <= w_e ? w_abs[i][32:1] : w_abs[i][31:0];
                r_neg[i] <= w_r[i][32];
            end
            r_e    <= w_e;
            r_m    <= i_item.body_mass;
            r_last <= i_item.last_body;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_opa * w_opb;
        end
        if (i_cmd.s_clr) begin
            r_s <= r_prod;
        end else if (i_cmd.s_add) begin
            r_s <= r_s + r_prod;
        end
        if (i_cmd.gm_ld) begin
            r_gm <= r_prod;
        end
        if (i_cmd.p_lo) begin
            r_p <= {32'b0, r_prod};
        end else if (i_cmd.p_hi) begin
            r_p <= r_p + {r_prod, 32'b0};
        end
        if (i_cmd.sqrt_init) begin
            r_sx   <= r_s;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sx   <= {r_sx[61:0], 2'b00};
            r_srem <= w_sq_bit ? w_sq_diff[33:0] : w_sq_sh[33:0];
            r_root <= {r_root[30:0], w_sq_bit};
        end
        if (i_cmd.div_init) begin
            r_rem  <= w_d_hi;
            r_dlo  <= w_d_lo;
            r_dvs  <= w_d_dvs;
            r_quo  <= '0;
            r_dsat <= w_d_hi >= w_d_dvs;
        end else if (i_cmd.div_step) begin
            r_rem <= w_q_bit ? 64'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[63:0];
            r_dlo <= {r_dlo[62:0], 1'b0};
            r_quo <= {r_quo[62:0], w_q_bit};
        end
        if (i_cmd.mag_ld) begin
            r_mag <= w_div_res;
        end
        if (i_cmd.out_ld) begin
            r_out.field_x   <= w_cx[DATA_W-1:0];
            r_out.field_y   <= w_cy[DATA_W-1:0];
            r_out.field_z   <= w_cz[DATA_W-1:0];
            r_out.saturated <= w_cx[DATA_W] | w_cy[DATA_W] | w_cz[DATA_W];
        end
    end

    assign o_stat.l_zero = (r_root == '0);
    assign o_stat.last   = r_last;
    assign o_result      = r_out;

endmodule

### hw/rtl/gfa_ctrl.sv
// controller: sequences one item through the shared multiplier, sqrt and divider
// depends on gfa_pkg; drives gfa_datapath through t_dp_cmd
module gfa_ctrl import gfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [AXIS_W-1:0]  r_axis;
    logic [AXIS_W-1:0]  n_axis;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SQ_MUL;
                    n_axis  = AXIS_X;
                end
            end
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (r_axis == AXIS_Z) begin
                    n_state = S_SQRT_INIT;
                end else begin
                    n_state = S_SQ_MUL;
                    n_axis  = r_axis + 1'b1;
                end
            end
            S_SQRT_INIT: begin
                n_state = S_SQRT;
                n_cnt   = '0;
            end
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_GM_MUL;
                end
            end
            S_GM_MUL: n_state = S_GM_ACC;
            S_GM_ACC: n_state = i_stat.l_zero ? S_DONE : S_MAG_INIT;
            S_MAG_INIT: begin
                n_state = S_MAG_DIV;
                n_cnt   = '0;
            end
            S_MAG_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MAG_LD;
                end
            end
            S_MAG_LD: begin
                n_state = S_LO_MUL;
                n_axis  = AXIS_X;
            end
            S_LO_MUL: n_state = S_LO_ACC;
            S_LO_ACC: n_state = S_HI_MUL;
            S_HI_MUL: n_state = S_HI_ACC;
            S_HI_ACC: n_state = S_C_INIT;
            S_C_INIT: begin
                n_state = S_C_DIV;
                n_cnt   = '0;
            end
            S_C_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_C_ACC;
                end
            end
            S_C_ACC: begin
                if (r_axis == AXIS_Z) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LO_MUL;
                    n_axis  = r_axis + 1'b1;
                end
            end
            S_DONE: begin
                if (!i_stat.last || w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SQ_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
            end
            S_SQ_ACC: begin
                o_cmd.s_clr = (r_axis == AXIS_X);
                o_cmd.s_add = (r_axis != AXIS_X);
            end
            S_SQRT_INIT: o_cmd.sqrt_init = 1'b1;
            S_SQRT:      o_cmd.sqrt_step = 1'b1;
            S_GM_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GM;
            end
            S_GM_ACC: o_cmd.gm_ld = 1'b1;
            S_MAG_INIT: begin
                o_cmd.div_init = 1'b1;
                o_cmd.div_src  = DIV_MAG;
            end
            S_MAG_DIV: o_cmd.div_step = 1'b1;
            S_MAG_LD:  o_cmd.mag_ld   = 1'b1;
            S_LO_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MAG_LO;
            end
            S_LO_ACC: o_cmd.p_lo = 1'b1;
            S_HI_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MAG_HI;
            end
            S_HI_ACC: o_cmd.p_hi = 1'b1;
            S_C_INIT: begin
                o_cmd.div_init = 1'b1;
                o_cmd.div_src  = DIV_CMP;
            end
            S_C_DIV: o_cmd.div_step = 1'b1;
            S_C_ACC: o_cmd.sum_acc  = 1'b1;
            S_DONE: begin
                if (i_stat.last && w_slot_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.sum_clr = 1'b1;
                    n_out_valid   = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= AXIS_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("controller took a second beat while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before its beat was taken");

    a_result_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_stat.last)
        else $error("result emitted for an item not marked last");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis != 2'd3)
        else $error("axis counter out of range");

    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

### tb/sv/gravity_field_accumulator_tb.sv
// testbench for gravity_field_accumulator: random and directed field beats checked
// against an in-bench fixed point predictor; depends on gfa_pkg, gfa_stream_if and the DUT
`timescale 1ns / 100ps

module gravity_field_accumulator_tb;
    import gfa_pkg::*;

    localparam int FRAC = 16;
    localparam int SUMW = 48;
    localparam longint SUM_HI = (64'sd1 <<< (SUMW - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int SETTLE_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;

    gfa_stream_if #(.T(t_item))   item_ch ();
    gfa_stream_if #(.T(t_result)) result_ch ();
    gfa_stream_if #(.T(t_cfg))    cfg_ch ();

    gravity_field_accumulator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    // predictor state: configuration copy and running field sums
    logic [31:0] g_const;
    logic [15:0] soft_sq;
    longint      field_acc [3];

    t_item   beats_pending [$];
    t_cfg    cfg_pending [$];
    t_result fields_due [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatches;
    int cycles;
    bit stim_done;

    // restoring square root of a 64 bit value
    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // 128 by 64 quotient, all ones when it does not fit 64 bits
    function automatic logic [63:0] wide_quot(logic [127:0] num, logic [63:0] d);
        logic [127:0] q;
        if (num[127:64] >= d) return '1;
        q = num / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic void add_axis(int ax, logic [63:0] c, bit neg);
        longint cs;
        if (c > 64'(SUM_HI)) c = 64'(SUM_HI);
        cs = longint'(c);
        if (!neg) field_acc[ax] = (field_acc[ax] > SUM_HI - cs) ? SUM_HI : field_acc[ax] + cs;
        else      field_acc[ax] = (field_acc[ax] < SUM_LO + cs) ? SUM_LO : field_acc[ax] - cs;
    endfunction

    function automatic logic [31:0] clip_field(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // one body's pull on the sample point, plus emit on the last body
    function automatic void predict_field(t_item it);
        longint       sep [3];
        logic [63:0]  mag_a [3];
        bit           neg [3];
        logic [63:0]  s2, l, t, gm, mag;
        logic [127:0] prod;
        int           k, e;
        bit           sat;
        t_result      res;
        e  = 0;
        s2 = 0;
        sep[0] = longint'(it.body_x) - longint'(it.point_x);
        sep[1] = longint'(it.body_y) - longint'(it.point_y);
        sep[2] = longint'(it.body_z) - longint'(it.point_z);
        for (int i = 0; i < 3; i++) begin
            neg[i]   = sep[i] < 0;
            mag_a[i] = neg[i] ? 64'(-sep[i]) : 64'(sep[i]);
            if (mag_a[i] >= 64'h8000_0000) e = 1;
        end
        for (int i = 0; i < 3; i++) begin
            mag_a[i] = mag_a[i] >> e;
            s2 += mag_a[i] * mag_a[i];
        end
        l = root_floor(s2);
        // zero distance adds nothing
        if (l != 0) begin
            k   = FRAC - 2 * e;
            t   = s2 + (64'(soft_sq) << k);
            gm  = 64'(g_const) * 64'(it.body_mass);
            mag = wide_quot(128'(gm) << k, t);
            for (int i = 0; i < 3; i++) begin
                prod = 128'(mag) * 128'(mag_a[i]);
                add_axis(i, wide_quot(prod, l), neg[i]);
            end
        end
        if (it.last_body) begin
            sat = 0;
            res.field_x   = clip_field(field_acc[0], sat);
            res.field_y   = clip_field(field_acc[1], sat);
            res.field_z   = clip_field(field_acc[2], sat);
            res.saturated = sat;
            fields_due = {fields_due, res};
            for (int i = 0; i < 3; i++) field_acc[i] = 0;
        end
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // item driver: predicts at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_field(item_ch.data);
                void'(beats_pending.pop_front());
            end
            if (beats_pending.size() > 0 &&
                    ((item_ch.valid && !item_ch.ready) ||
                     $urandom_range(99) >= sender_idle_pct)) begin
                item_ch.valid <= 1;
                item_ch.data  <= (item_ch.valid && item_ch.ready) ?
                                 beats_pending[0] : beats_pending[0];
            end else begin
                item_ch.valid <= 0;
            end
        end
    end

    // config driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.data.index == REG_GRAV_CONST) g_const = cfg_ch.data.value;
                else if (cfg_ch.data.index == REG_SOFTENING_SQ) soft_sq = cfg_ch.data.value[15:0];
                void'(cfg_pending.pop_front());
            end
            if (cfg_pending.size() > 0) begin
                cfg_ch.valid <= 1;
                cfg_ch.data  <= cfg_pending[0];
            end else begin
                cfg_ch.valid <= 0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (fields_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", result_ch.data);
                end else begin
                    if (result_ch.data !== fields_due[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field mismatch: exp %p got %p",
                                     fields_due[0], result_ch.data);
                    end
                    void'(fields_due.pop_front());
                end
            end
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return 32'h8000_0000 + $urandom_range(3);
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic t_item rand_item(bit last);
        t_item it;
        it.point_x = rand_coord();
        it.point_y = rand_coord();
        it.point_z = rand_coord();
        it.body_x  = rand_coord();
        it.body_y  = rand_coord();
        it.body_z  = rand_coord();
        case ($urandom_range(3))
            0: it.body_mass = $urandom;
            1: it.body_mass = '1;
            default: it.body_mass = $urandom_range(1 << 20);
        endcase
        // coincident body now and then
        if ($urandom_range(19) == 0) begin
            it.body_x = it.point_x;
            it.body_y = it.point_y;
            it.body_z = it.point_z;
        end
        it.last_body = last;
        return it;
    endfunction

    task automatic drain();
        while (beats_pending.size() > 0 || fields_due.size() > 0 || cfg_pending.size() > 0)
            @(posedge i_clk);
        // an item without a result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        t_cfg c;
        c.index = idx;
        c.value = val;
        cfg_pending = {cfg_pending, c};
    endtask

    task automatic queue_points(int n);
        int left;
        for (int p = 0; p < n; p++) begin
            left = $urandom_range(4) + 1;
            for (int b = 0; b < left; b++)
                beats_pending = {beats_pending, rand_item(b == left - 1)};
        end
    endtask

    initial begin
        t_item it;
        int phase_idle [4];
        int phase_stall [4];
        phase_idle  = '{0, 62, 0, 26};
        phase_stall = '{0, 0, 62, 26};
        item_ch.valid   = 0;
        item_ch.data    = '0;
        cfg_ch.valid    = 0;
        cfg_ch.data     = '0;
        result_ch.ready = 0;
        g_const = GRAV_CONST_RST;
        soft_sq = SOFT_SQ_RST;
        for (int i = 0; i < 3; i++) field_acc[i] = 0;
        mismatches = 0;
        cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, coincident body, sum saturation
        it = '0;
        it.body_x = 32'sd65536; it.body_mass = 32'd65536; it.last_body = 1;
        beats_pending = {beats_pending, it};
        it = '0; it.body_mass = '1; it.last_body = 1;
        beats_pending = {beats_pending, it};
        it.point_x = 32'h8000_0000; it.point_y = 32'h8000_0000; it.point_z = 32'h8000_0000;
        it.body_x = 32'h7fff_ffff; it.body_y = 32'h7fff_ffff; it.body_z = 32'h7fff_ffff;
        beats_pending = {beats_pending, it};
        it.point_x = 32'h7fff_ffff; it.point_y = 32'h7fff_ffff; it.point_z = 32'h7fff_ffff;
        it.body_x = 32'h8000_0000; it.body_y = 32'h8000_0000; it.body_z = 32'h8000_0000;
        beats_pending = {beats_pending, it};
        it = '0; it.body_y = -32'sd1; it.body_mass = '1; it.last_body = 0;
        for (int i = 0; i < 6; i++) beats_pending = {beats_pending, it};
        it.last_body = 1;
        beats_pending = {beats_pending, it};
        it = '0; it.body_z = 32'sd1; it.body_mass = '1; it.last_body = 1;
        beats_pending = {beats_pending, it};
        for (int i = 0; i < 8; i++) beats_pending = {beats_pending, rand_item(bit'(i % 2))};
        drain();

        // config extremes, then random phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_GRAV_CONST, '1);
                    write_reg(REG_SOFTENING_SQ, 32'd0);
                end
                1: begin
                    write_reg(REG_GRAV_CONST, 32'd0);
                    write_reg(REG_SOFTENING_SQ, 32'h0000_ffff);
                end
                2: begin
                    write_reg(REG_GRAV_CONST, $urandom);
                    write_reg(REG_SOFTENING_SQ, $urandom);
                end
                default: begin
                    write_reg(REG_GRAV_CONST, GRAV_CONST_RST);
                    write_reg(REG_SOFTENING_SQ, 32'(SOFT_SQ_RST));
                    write_reg(8'd7, $urandom);
                end
            endcase
            drain();
            sender_idle_pct    = phase_idle[ph];
            receiver_stall_pct = phase_stall[ph];
            queue_points(107);
            drain();
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
        end

        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/gfa_pkg.sv
hw/rtl/gfa_stream_if.sv
hw/rtl/gfa_datapath.sv
hw/rtl/gfa_ctrl.sv
hw/rtl/gravity_field_accumulator.sv
tb/sv/gravity_field_accumulator_tb.sv
